// ----- hdl/ktls_pkg.sv -----
package ktls_pkg;

  // Default sizes
  localparam int SLOTS_DEF    = 64;
  localparam int KEY_BITS_DEF = 16;
  localparam int CAP_BITS_DEF = 16;

  // Fixed field widths on the ports
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 22;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  // Control part of the search token that walks the cell chain
  typedef struct packed {
    logic active;
    logic found;
  } scan_ctl_t;

endpackage

// ----- hdl/ktls_cell.sv -----
module ktls_cell
  import ktls_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int CAPACITY_BITS = CAP_BITS_DEF,
  parameter int CELL_IDX      = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [KEY_BITS-1:0]            scan_key,
  input  logic [$clog2(SLOTS+1)-1:0]     entry_cnt,
  input  logic                           wr_en,
  input  logic [$clog2(SLOTS)-1:0]       wr_idx,
  input  logic [KEY_BITS-1:0]            wr_key,
  input  logic [CAPACITY_BITS-1:0]       wr_cap,
  input  scan_ctl_t                      tok_in,
  input  logic [$clog2(SLOTS)-1:0]       idx_in,
  input  logic [CAPACITY_BITS-1:0]       fcap_in,
  input  logic [KEY_BITS-1:0]            lkey_in,
  input  logic [CAPACITY_BITS-1:0]       lcap_in,
  output scan_ctl_t                      tok_out,
  output logic [$clog2(SLOTS)-1:0]       idx_out,
  output logic [CAPACITY_BITS-1:0]       fcap_out,
  output logic [KEY_BITS-1:0]            lkey_out,
  output logic [CAPACITY_BITS-1:0]       lcap_out
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);

  logic [KEY_BITS-1:0]      key_r;
  logic [CAPACITY_BITS-1:0] cap_r;

  scan_ctl_t                tok_r, tok_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [CAPACITY_BITS-1:0] fcap_r, fcap_nxt;
  logic [KEY_BITS-1:0]      lkey_r, lkey_nxt;
  logic [CAPACITY_BITS-1:0] lcap_r, lcap_nxt;

  logic in_range;
  logic is_last;
  logic hit;

  assign in_range = (MY_CNT < entry_cnt);
  assign is_last  = (MY_NEXT == entry_cnt);
  assign hit      = tok_in.active && !tok_in.found && in_range && (key_r == scan_key);

  always_comb begin
    tok_nxt.active = tok_in.active;
    tok_nxt.found  = tok_in.found | hit;
    idx_nxt        = hit ? MY_IDX : idx_in;
    fcap_nxt       = hit ? cap_r : fcap_in;
    // pick up the tail entry on the way past, erase copies it back
    lkey_nxt       = (tok_in.active && is_last) ? key_r : lkey_in;
    lcap_nxt       = (tok_in.active && is_last) ? cap_r : lcap_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    fcap_r <= fcap_nxt;
    lkey_r <= lkey_nxt;
    lcap_r <= lcap_nxt;
    if (wr_en && (wr_idx == MY_IDX)) begin
      key_r <= wr_key;
      cap_r <= wr_cap;
    end
  end

  assign tok_out  = tok_r;
  assign idx_out  = idx_r;
  assign fcap_out = fcap_r;
  assign lkey_out = lkey_r;
  assign lcap_out = lcap_r;

endmodule

// ----- hdl/keyed_table_linear_search_core.sv -----
// channel   | ports                                              | handshake
// ----------+----------------------------------------------------+-----------------------
// request   | in_operation, in_key, in_capacity                  | start high, busy low
// result    | out_status, out_slot_index, out_found_capacity,    | out_strobe, one cycle
//           | out_entry_count, out_total_capacity                |
//
// Insert and clear answer in the cycle after the beat; busy does not rise.
// Lookup and erase hold busy while a search token walks the cell chain one
// cell per clock; then the result is formed and registered.
// Reset (rst_n low, synchronous) empties the table; stored entries are not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module keyed_table_linear_search_core
  import ktls_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int CAPACITY_BITS = CAP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [KEY_BITS-1:0]      in_key,
  input  logic [CAPACITY_BITS-1:0] in_capacity,
  output logic                     out_strobe,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot_index,
  output logic [CAPACITY_BITS-1:0] out_found_capacity,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic [TOTAL_W-1:0]       out_total_capacity
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int SUM_W = CAPACITY_BITS + CNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic                     inject_r, inject_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;

  logic                     strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CAPACITY_BITS-1:0] fcap_r, fcap_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;

  logic                     accept;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic [KEY_BITS-1:0]      wr_key;
  logic [CAPACITY_BITS-1:0] wr_cap;

  scan_ctl_t                tok_ctl  [0:SLOTS];
  logic [IDX_W-1:0]         tok_idx  [0:SLOTS];
  logic [CAPACITY_BITS-1:0] tok_fcap [0:SLOTS];
  logic [KEY_BITS-1:0]      tok_lkey [0:SLOTS];
  logic [CAPACITY_BITS-1:0] tok_lcap [0:SLOTS];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // chain head
  assign tok_ctl[0]  = '{active: inject_r, found: 1'b0};
  assign tok_idx[0]  = '0;
  assign tok_fcap[0] = '0;
  assign tok_lkey[0] = '0;
  assign tok_lcap[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ktls_cell #(
      .SLOTS         (SLOTS),
      .KEY_BITS      (KEY_BITS),
      .CAPACITY_BITS (CAPACITY_BITS),
      .CELL_IDX      (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .scan_key  (key_r),
      .entry_cnt (cnt_r),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_key    (wr_key),
      .wr_cap    (wr_cap),
      .tok_in    (tok_ctl[g]),
      .idx_in    (tok_idx[g]),
      .fcap_in   (tok_fcap[g]),
      .lkey_in   (tok_lkey[g]),
      .lcap_in   (tok_lcap[g]),
      .tok_out   (tok_ctl[g+1]),
      .idx_out   (tok_idx[g+1]),
      .fcap_out  (tok_fcap[g+1]),
      .lkey_out  (tok_lkey[g+1]),
      .lcap_out  (tok_lcap[g+1])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    inject_nxt = 1'b0;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    fcap_nxt   = fcap_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    wr_en      = 1'b0;
    wr_idx     = tok_idx[SLOTS];
    wr_key     = in_key;
    wr_cap     = in_capacity;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = op_t'(in_operation);
          key_nxt = in_key;
          unique case (op_t'(in_operation))
            OP_INSERT: begin
              strobe_nxt = 1'b1;
              fcap_nxt   = '0;
              if (cnt_r == FULL_CNT) begin
                status_nxt = ST_FULL;
                slot_nxt   = '0;
              end else begin
                wr_en      = 1'b1;
                wr_idx     = cnt_r[IDX_W-1:0];
                cnt_nxt    = cnt_r + 1'b1;
                sum_nxt    = sum_r + SUM_W'(in_capacity);
                status_nxt = ST_OK;
                slot_nxt   = SLOT_W'(cnt_r);
              end
              count_nxt = COUNT_W'(cnt_nxt);
              total_nxt = TOTAL_W'(sum_nxt);
            end
            OP_LOOKUP, OP_ERASE: begin
              state_nxt  = S_SCAN;
              inject_nxt = 1'b1;
            end
            OP_CLEAR: begin
              cnt_nxt    = '0;
              sum_nxt    = '0;
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
              slot_nxt   = '0;
              fcap_nxt   = '0;
              count_nxt  = '0;
              total_nxt  = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // token has left the last cell: finish the request
        if (tok_ctl[SLOTS].active) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          fcap_nxt   = '0;
          if (!tok_ctl[SLOTS].found) begin
            status_nxt = ST_MISS;
            slot_nxt   = '0;
          end else if (op_r == OP_LOOKUP) begin
            status_nxt = ST_OK;
            slot_nxt   = SLOT_W'(tok_idx[SLOTS]);
            fcap_nxt   = tok_fcap[SLOTS];
          end else begin
            // swap-remove: move the tail entry into the hole
            wr_en      = 1'b1;
            wr_key     = tok_lkey[SLOTS];
            wr_cap     = tok_lcap[SLOTS];
            cnt_nxt    = cnt_r - 1'b1;
            sum_nxt    = sum_r - SUM_W'(tok_fcap[SLOTS]);
            status_nxt = ST_OK;
            slot_nxt   = SLOT_W'(tok_idx[SLOTS]);
          end
          count_nxt = COUNT_W'(cnt_nxt);
          total_nxt = TOTAL_W'(sum_nxt);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inject_r <= 1'b0;
      cnt_r    <= '0;
      sum_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= inject_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    fcap_r   <= fcap_nxt;
    count_r  <= count_nxt;
    total_r  <= total_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_slot_index     = slot_r;
  assign out_found_capacity = fcap_r;
  assign out_entry_count    = count_r;
  assign out_total_capacity = total_r;

  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_ctl[SLOTS].active |-> (state_r == S_SCAN))
    else $error("search token left the chain outside a search");

  a_quick_ops_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_INSERT || in_operation == OP_CLEAR)) |=> strobe_r)
    else $error("insert or clear gave no result in the next cycle");

  a_search_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_LOOKUP || in_operation == OP_ERASE))
      |=> (busy && !strobe_r))
    else $error("search did not hold off new requests");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_ctl[SLOTS].active && tok_ctl[SLOTS].found) |-> (CNT_W'(tok_idx[SLOTS]) < cnt_r))
    else $error("search hit beyond the filled slots");

endmodule
